// ===== hw/rtl/eqlt_pkg.sv =====
// ----------------------------------------------------------------------------
// eqlt_pkg
// Shared types and constants for the escaped quoted line tokenizer.
// ----------------------------------------------------------------------------
package eqlt_pkg;

    // Input item kinds (carried on tuser)
    localparam logic REQ_CHAR = 1'b0;
    localparam logic REQ_EOL  = 1'b1;

    // Result kinds (carried on tuser)
    localparam logic [1:0] KIND_CHAR      = 2'd0;
    localparam logic [1:0] KIND_TOKEN_END = 2'd1;
    localparam logic [1:0] KIND_LINE_END  = 2'd2;

    // Special bytes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    localparam int MAX_TOKENS_DEF = 255;
    localparam int FIFO_DEPTH     = 8;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_char;
        logic [7:0] token_index;
        logic       last;
    } t_result;

    // Up to two results produced by one input transaction
    typedef struct packed {
        logic [1:0] num;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

// ===== hw/rtl/eqlt_step.sv =====
// ----------------------------------------------------------------------------
// eqlt_step
// Input register, tokenizer state and the per-byte decision logic.
// ----------------------------------------------------------------------------
module eqlt_step #(
    parameter int MAX_TOKENS = eqlt_pkg::MAX_TOKENS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic           i_req_type,
    input  logic [7:0]     i_ch,
    output logic           o_busy,
    output eqlt_pkg::t_push o_push
);

    localparam logic [7:0] LIMIT = 8'((MAX_TOKENS > 255) ? 255 : MAX_TOKENS);

    logic       r_in_valid;
    logic       r_req;
    logic [7:0] r_ch;

    logic       r_esc, r_quote, r_comment, r_nonempty;
    logic [7:0] r_cnt;
    logic       n_esc, n_quote, n_comment, n_nonempty;
    logic [7:0] n_cnt;

    eqlt_pkg::t_push push;

    always_comb begin
        n_esc      = r_esc;
        n_quote    = r_quote;
        n_comment  = r_comment;
        n_nonempty = r_nonempty;
        n_cnt      = r_cnt;
        push       = '0;
        // default first result: a token character
        push.r0.kind        = eqlt_pkg::KIND_CHAR;
        push.r0.out_char    = r_ch;
        push.r0.token_index = r_cnt;
        push.r0.last        = 1'b1;

        if (r_req == eqlt_pkg::REQ_EOL) begin
            if (!r_comment && r_nonempty) begin
                push.num            = 2'd2;
                push.r0.kind        = eqlt_pkg::KIND_TOKEN_END;
                push.r0.out_char    = '0;
                push.r0.last        = 1'b0;
                push.r1.kind        = eqlt_pkg::KIND_LINE_END;
                push.r1.token_index = (r_cnt < LIMIT) ? r_cnt + 8'd1 : r_cnt;
                push.r1.last        = 1'b1;
            end else begin
                push.num         = 2'd1;
                push.r0.kind     = eqlt_pkg::KIND_LINE_END;
                push.r0.out_char = '0;
            end
            n_esc      = 1'b0;
            n_quote    = 1'b0;
            n_comment  = 1'b0;
            n_nonempty = 1'b0;
            n_cnt      = '0;
        end else if (r_comment || (r_ch inside {eqlt_pkg::CH_NUL, eqlt_pkg::CH_CR})) begin
            push.num = 2'd0;
        end else begin
            case (r_ch)
                eqlt_pkg::CH_BSL: begin
                    if (r_esc) begin
                        push.num = 2'd1;
                        n_esc    = 1'b0;
                    end else begin
                        n_esc = 1'b1;
                    end
                end
                eqlt_pkg::CH_HASH: begin
                    if (r_esc || r_quote) begin
                        push.num = 2'd1;
                        n_esc    = 1'b0;
                    end else begin
                        n_comment = 1'b1;
                    end
                end
                eqlt_pkg::CH_QUOTE: begin
                    if (r_esc) begin
                        push.num = 2'd1;
                        n_esc    = 1'b0;
                    end else begin
                        n_quote = ~r_quote;
                    end
                end
                eqlt_pkg::CH_SPACE, eqlt_pkg::CH_TAB: begin
                    if (r_quote) begin
                        push.num = 2'd1;       // quoted: escape stays pending
                    end else if (r_esc) begin
                        push.num = 2'd1;
                        n_esc    = 1'b0;
                    end
                end
                default: begin
                    push.num = 2'd1;           // ordinary byte keeps the escape
                end
            endcase

            // unquoted, unescaped break or comment start closes the token
            if (push.num == 2'd0 && !r_esc && !r_quote &&
                (r_ch inside {eqlt_pkg::CH_SPACE, eqlt_pkg::CH_TAB, eqlt_pkg::CH_HASH})) begin
                if (r_nonempty) begin
                    push.num         = 2'd1;
                    push.r0.kind     = eqlt_pkg::KIND_TOKEN_END;
                    push.r0.out_char = '0;
                    n_cnt            = (r_cnt < LIMIT) ? r_cnt + 8'd1 : r_cnt;
                end
                n_nonempty = 1'b0;
            end else if (push.num != 2'd0) begin
                n_nonempty = 1'b1;
            end
        end

        if (!r_in_valid) begin
            push.num = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_req <= i_req_type;
            r_ch  <= i_ch;
        end
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_esc      <= 1'b0;
            r_quote    <= 1'b0;
            r_comment  <= 1'b0;
            r_nonempty <= 1'b0;
            r_cnt      <= '0;
        end else begin
            r_in_valid <= i_accept;
            if (r_in_valid) begin
                r_esc      <= n_esc;
                r_quote    <= n_quote;
                r_comment  <= n_comment;
                r_nonempty <= n_nonempty;
                r_cnt      <= n_cnt;
            end
        end
    end

    assign o_busy = r_in_valid;
    assign o_push = push;

endmodule

// ===== hw/rtl/eqlt_fifo.sv =====
// ----------------------------------------------------------------------------
// eqlt_fifo
// Result queue taking up to two results per cycle, one out per cycle.
// ----------------------------------------------------------------------------
module eqlt_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  eqlt_pkg::t_push   i_push,
    input  logic              i_pop,
    output logic              o_valid,
    output eqlt_pkg::t_result o_head,
    output logic [$clog2(eqlt_pkg::FIFO_DEPTH):0] o_count
);

    localparam int DEPTH = eqlt_pkg::FIFO_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    eqlt_pkg::t_result r_mem [DEPTH];
    logic [AW-1:0]     r_wp, r_rp;
    logic [AW:0]       r_count;
    logic [AW-1:0]     wp1;
    logic              pop;

    assign wp1 = r_wp + AW'(1);
    assign pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wp] <= i_push.r0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wp1] <= i_push.r1;
        end
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + AW'(i_push.num);
            r_rp    <= r_rp + AW'(pop);
            r_count <= r_count + (AW+1)'(i_push.num) - (AW+1)'(pop);
        end
    end

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rp];
    assign o_count = r_count;

endmodule

// ===== hw/rtl/escaped_quoted_line_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// escaped_quoted_line_tokenizer_core
// Shell-style line tokenizer: bytes in, token characters and markers out.
// ----------------------------------------------------------------------------
// Feed the bytes of one line with s_axis_tuser low, then one transaction with
// s_axis_tuser high to close the line. Tokens split at unquoted, unescaped
// space or tab; a double quote toggles quoting; backslash escapes backslash,
// '#', quote, space and tab; CR and NUL bytes are dropped; an unquoted,
// unescaped '#' closes the token and skips to end of line. Each kept byte
// comes out as a token character (tuser 0), each non-empty token is closed
// by a token end (tuser 1), and every line ends with a line end (tuser 2)
// carrying the token count. tlast marks the final output of each input
// transaction. Throughput: one input byte per clock while the queue has room.
// An input is registered, decoded in the following cycle and its one or two
// results are queued; an end of line that closes a token produces two
// results. A small output queue decouples the sides; input stalls unless it
// has room for two results each for the registered item and a new one.
// ----------------------------------------------------------------------------
module escaped_quoted_line_tokenizer_core #(
    parameter int MAX_TOKENS = eqlt_pkg::MAX_TOKENS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  logic        s_axis_tuser,   // [0] req_type
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_char, [15:8] token_index
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast    // last
);

    localparam int DEPTH = eqlt_pkg::FIFO_DEPTH;
    localparam int CW    = $clog2(DEPTH) + 1;

    logic              accept;
    logic              busy;
    eqlt_pkg::t_push   push;
    eqlt_pkg::t_result head;
    logic [CW-1:0]     count;

    // Room for the item in the input register and for a new one, two each.
    assign s_axis_tready = ((count + (busy ? CW'(2) : CW'(0))) <= CW'(DEPTH - 2));
    assign accept        = s_axis_tvalid && s_axis_tready;

    eqlt_step #(
        .MAX_TOKENS (MAX_TOKENS)
    ) u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_req_type (s_axis_tuser),
        .i_ch       (s_axis_tdata),
        .o_busy     (busy),
        .o_push     (push)
    );

    eqlt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_head  (head),
        .o_count (count)
    );

    assign m_axis_tdata = {head.token_index, head.out_char};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

endmodule
